### rtl/tlcd_pkg.sv
// Shared types, constants and helpers of the character-LCD nibble writer.
package tlcd_pkg;

	localparam logic [6:0] MAX_COLUMNS   = 7'd64;
	localparam logic [2:0] ROW_LIMIT     = 3'd4;
	localparam logic [6:0] COLUMNS_RESET = 7'd16;
	localparam logic [2:0] ROWS_RESET    = 3'd2;

	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [7:0] CHAR_NL      = 8'd10;
	localparam logic [7:0] CHAR_CR      = 8'd13;

	localparam logic OP_PUT   = 1'b0;
	localparam logic OP_PLACE = 1'b1;

	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	localparam int QUEUE_DEPTH = 2;

	// One or two bus bytes produced by one item
	typedef struct packed {
		logic       two;
		logic       rs0;
		logic [7:0] b0;
		logic       rs1;
		logic [7:0] b1;
	} job_t;

	function automatic logic [7:0] row_base(input logic [1:0] row);
		logic [7:0] base;
		case (row)
			2'd0: base = 8'h00;
			2'd1: base = 8'h40;
			2'd2: base = 8'h10;
			default: base = 8'h50;
		endcase
		return base;
	endfunction

	// Row at or past the row count folds to row 0
	function automatic logic [1:0] fold_row(input logic [2:0] row, input logic [2:0] rows);
		return (row >= rows) ? 2'd0 : row[1:0];
	endfunction

	// Set-address command for a column and row
	function automatic logic [7:0] addr_cmd(input logic [6:0] col, input logic [1:0] row);
		return CMD_SET_ADDR | ({1'b0, col} + row_base(row));
	endfunction

endpackage

### rtl/tlcd_if.sv
// Channel interfaces: text items in, bus nibbles out.
interface tlcd_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] character;
	logic [5:0] target_col;
	logic [2:0] target_row;

	modport source (output valid, operation, character, target_col, target_row, input ready);
	modport sink (input valid, operation, character, target_col, target_row, output ready);
endinterface

interface tlcd_out_if;
	logic       valid;
	logic       ready;
	logic       register_select;
	logic [3:0] nibble;
	logic       last_of_run;

	modport source (output valid, register_select, nibble, last_of_run, input ready);
	modport sink (input valid, register_select, nibble, last_of_run, output ready);
endinterface

### rtl/tlcd_front.sv
// Front end: config registers, cursor tracking and byte generation per item.
module tlcd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [6:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [7:0]         character,
	input  logic [5:0]         target_col,
	input  logic [2:0]         target_row,
	output logic               push_valid,
	input  logic               push_ready,
	output tlcd_pkg::job_t     push_data
);
	import tlcd_pkg::*;

	logic [6:0] columns_q;
	logic [2:0] rows_q;
	logic [6:0] cursor_col_q;
	logic [1:0] cursor_row_q;

	logic [6:0] eff_cols;
	logic [2:0] eff_rows;
	logic       wrap;
	logic [1:0] wrap_row;
	logic [6:0] col_a;
	logic [1:0] row_a;
	logic [6:0] col_n;
	logic [1:0] row_n;
	logic       rs_main;
	logic [7:0] byte_main;
	logic       accept;

	assign eff_cols = (columns_q > MAX_COLUMNS) ? MAX_COLUMNS : columns_q;
	assign eff_rows = (rows_q > ROW_LIMIT) ? ROW_LIMIT : rows_q;

	// wrap to the next row before a character once past the width
	assign wrap     = (operation == OP_PUT) && (cursor_col_q >= eff_cols);
	assign wrap_row = fold_row({1'b0, cursor_row_q} + 3'd1, eff_rows);
	assign col_a    = wrap ? 7'd0 : cursor_col_q;
	assign row_a    = wrap ? wrap_row : cursor_row_q;

	always_comb begin
		col_n     = col_a;
		row_n     = row_a;
		rs_main   = RS_CMD;
		byte_main = 8'h00;
		if (operation == OP_PLACE) begin
			col_n     = {1'b0, target_col};
			row_n     = fold_row(target_row, eff_rows);
			byte_main = addr_cmd(col_n, row_n);
		end else if (character == CHAR_NL) begin
			row_n     = fold_row({1'b0, row_a} + 3'd1, eff_rows);
			byte_main = addr_cmd(col_a, row_n);
		end else if (character == CHAR_CR) begin
			col_n     = 7'd0;
			row_n     = fold_row({1'b0, row_a}, eff_rows);
			byte_main = addr_cmd(7'd0, row_n);
		end else begin
			col_n     = col_a + 7'd1;
			rs_main   = RS_DATA;
			byte_main = character;
		end
	end

	always_comb begin
		push_data.two = wrap;
		if (wrap) begin
			push_data.rs0 = RS_CMD;
			push_data.b0  = addr_cmd(7'd0, wrap_row);
			push_data.rs1 = rs_main;
			push_data.b1  = byte_main;
		end else begin
			push_data.rs0 = rs_main;
			push_data.b0  = byte_main;
			push_data.rs1 = RS_CMD;
			push_data.b1  = 8'h00;
		end
	end

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q    <= COLUMNS_RESET;
			rows_q       <= ROWS_RESET;
			cursor_col_q <= 7'd0;
			cursor_row_q <= 2'd0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_COLUMNS) begin
					columns_q <= cfg_data;
				end else begin
					rows_q <= cfg_data[2:0];
				end
			end
			if (accept) begin
				cursor_col_q <= col_n;
				cursor_row_q <= row_n;
			end
		end
	end

endmodule

### rtl/tlcd_queue.sv
// Two-entry job queue between the front end and the nibble sequencer.
module tlcd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  tlcd_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output tlcd_pkg::job_t pop_data
);
	import tlcd_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### rtl/tlcd_back.sv
// Back end: splits queued bytes into high/low nibbles, one per cycle while out_ready is high.
module tlcd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  tlcd_pkg::job_t pop_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           register_select,
	output logic [3:0]     nibble,
	output logic           last_of_run
);
	import tlcd_pkg::*;

	job_t       job_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic [7:0] cur_byte;
	logic       fire;

	always_comb begin
		if (job_q.two && idx_q[1]) begin
			cur_byte        = job_q.b1;
			register_select = job_q.rs1;
		end else begin
			cur_byte        = job_q.b0;
			register_select = job_q.rs0;
		end
	end

	assign nibble      = idx_q[0] ? cur_byte[3:0] : cur_byte[7:4];
	assign last_of_run = (idx_q == (job_q.two ? 2'd3 : 2'd1));
	assign out_valid   = busy_q;
	assign fire        = out_valid && out_ready;
	// load the next job when idle or as the last nibble leaves
	assign pop_ready   = !busy_q || (fire && last_of_run);

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			job_q <= pop_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else begin
			if (pop_ready) begin
				busy_q <= pop_valid;
				idx_q  <= 2'd0;
			end else if (fire) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

### rtl/text_to_char_lcd_nibble_stream.sv
// Top level of the character-LCD 4-bit text writer.
//
//   channel | direction | handshake    | payload
//   --------+-----------+--------------+-----------------------------------------------
//   text    | in        | valid/ready  | operation, character, target_col, target_row
//   bus     | out       | valid/ready  | register_select, nibble, last_of_run
//   cfg     | in        | cfg_we       | cfg_index (0 columns, 1 rows_in_use), cfg_data
//
// A text item becomes one or two bus bytes in the cycle it is accepted; the cursor
// updates at that same edge. The sequencer sends one nibble per cycle while bus ready is
// high, so an item is two nibbles (data byte, cursor move) or four (row wrap plus byte);
// the nibble sequencer sets the rate. A two-entry job queue between the front end and the
// sequencer keeps text flowing while the bus stalls, until the queue fills. Reset returns
// the cursor to column 0, row 0, columns to 16, rows_in_use to 2, and empties the queue.
module text_to_char_lcd_nibble_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	tlcd_in_if.sink     text,
	tlcd_out_if.source  bus
);
	import tlcd_pkg::*;

	logic push_valid;
	logic push_ready;
	job_t push_data;
	logic pop_valid;
	logic pop_ready;
	job_t pop_data;

	// classify items, track the cursor
	tlcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (text.valid),
		.in_ready   (text.ready),
		.operation  (text.operation),
		.character  (text.character),
		.target_col (text.target_col),
		.target_row (text.target_row),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouple front and back
	tlcd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// emit nibbles, high half first
	tlcd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_data        (pop_data),
		.out_valid       (bus.valid),
		.out_ready       (bus.ready),
		.register_select (bus.register_select),
		.nibble          (bus.nibble),
		.last_of_run     (bus.last_of_run)
	);

endmodule
